[hw/rtl/raw_to_srgb_curve_accumulator_assert.svh]
// Assertion macros for the raw-to-sRGB curve accumulator.
`ifndef RAW_TO_SRGB_CURVE_ACCUMULATOR_ASSERT_SVH
`define RAW_TO_SRGB_CURVE_ACCUMULATOR_ASSERT_SVH

// Check that cons holds in the same cycle as ante; uses clk and rst_n in scope.
`define RSCA_CHECK_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define RSCA_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/rsca_pkg.sv]
// Package: item types, store geometry and the sRGB linearisation table.
`timescale 1ns / 1ps
`default_nettype none

package rsca_pkg;

  localparam int BIN_BITS = 16;
  localparam int CHANNELS = 3;
  localparam int RAW_W    = 16;
  localparam int DEPTH    = CHANNELS << BIN_BITS;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int MEAN_W   = 16;
  localparam int COUNT_W  = 32;
  localparam int PROD_W   = MEAN_W + COUNT_W;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    OP_ACCUM = 2'd0,
    OP_READ  = 2'd1,
    OP_LOAD  = 2'd2
  } opcode_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [1:0]         channel;
    logic [RAW_W-1:0]   raw_value;
    logic [7:0]         ref_value;
    logic [MEAN_W-1:0]  load_mean;
    logic [COUNT_W-1:0] load_count;
  } in_item_t;

  typedef struct packed {
    logic [MEAN_W-1:0]  mean_out;
    logic [COUNT_W-1:0] count_out;
  } out_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [MEAN_W-1:0]  mean;
  } bin_word_t;

  typedef logic [255:0][MEAN_W-1:0] lut_t;

  // Linear segment: round(655350*i / 32946); power segment in Q31 fixed point.
  localparam longint unsigned LIN_NUM  = 655350;
  localparam longint unsigned LIN_DEN  = 32946;
  localparam longint unsigned LIN_DEN2 = 2 * LIN_DEN;
  localparam longint unsigned PWR_DEN  = 269025;
  localparam longint unsigned Q31_ONE  = 64'd1 << 31;

  // Restoring long division, used only while the table is built
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    int          b;
    quo = '0;
    rem = '0;
    for (b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic lut_t build_srgb_lut();
    lut_t                  lut;
    logic [63:0]           n;
    logic [63:0]           t;
    logic [63:0]           s;
    logic [63:0]           lo;
    logic [63:0]           hi;
    logic [63:0]           mid;
    logic [63:0]           p;
    logic [63:0]           y;
    int                    code;
    int                    step;
    int                    k;
    for (code = 0; code < 256; code++) begin
      if (code <= 10) begin
        y = udiv64(LIN_NUM * 64'(code) * 64'd2 + LIN_DEN, LIN_DEN2);
      end else begin
        n  = 64'd1000 * 64'(code) + 64'd14025;
        t  = udiv64(n << 31, PWR_DEN);
        s  = (t * t) >> 31;
        lo = 64'd0;
        hi = Q31_ONE;
        // fifth root by bisection over [0, 1.0]
        for (step = 0; step < 33; step++) begin
          if (lo < hi) begin
            mid = (lo + hi + 64'd1) >> 1;
            p   = mid;
            for (k = 0; k < 4; k++) begin
              p = (p * mid) >> 31;
            end
            if (p <= s) begin
              lo = mid;
            end else begin
              hi = mid - 64'd1;
            end
          end
        end
        y = (s * lo) >> 31;
        y = (y * 64'd65535 + (64'd1 << 30)) >> 31;
      end
      if (y > 64'd65535) begin
        y = 64'd65535;
      end
      lut[code] = y[MEAN_W-1:0];
    end
    return lut;
  endfunction

  localparam lut_t SRGB_LUT = build_srgb_lut();

endpackage

`default_nettype wire

[hw/rtl/raw_to_srgb_curve_accumulator.sv]
// Top level: per-channel binned running-mean store with a serial rounding divider.
//
//   port group | dir | handshake           | payload
//   in_*       | in  | in_valid/in_ready   | in_data   (in_item_t)
//   out_*      | out | out_valid/out_ready | out_data  (out_item_t)
//
// One item in flight. Accumulate: read and multiply, add, 16 divider steps (one
// quotient bit per cycle), write-back, output; a saturated bin skips to output.
// Read, load and unused opcodes: read, output; an out-of-range channel goes
// straight to output. After reset a clearing pass writes zero to all
// CHANNELS << BIN_BITS bins with in_ready low. A result waiting at the output
// does not block acceptance; the next item stalls only at its own output step.
`timescale 1ns / 1ps
`default_nettype none

`include "raw_to_srgb_curve_accumulator_assert.svh"

module raw_to_srgb_curve_accumulator import rsca_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  localparam int QUO_W  = MEAN_W;
  localparam int STEP_W = $clog2(QUO_W);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD,
    S_ADD,
    S_DIV,
    S_FIN,
    S_OUT
  } state_t;

  state_t             state_r,     state_nxt;
  logic [ADDR_W-1:0]  clr_addr_r,  clr_addr_nxt;
  logic [ADDR_W-1:0]  addr_r,      addr_nxt;
  logic [1:0]         op_r,        op_nxt;
  logic [MEAN_W-1:0]  v_r,         v_nxt;
  logic [MEAN_W-1:0]  ld_mean_r,   ld_mean_nxt;
  logic [COUNT_W-1:0] ld_count_r,  ld_count_nxt;
  logic [PROD_W-1:0]  prod_r,      prod_nxt;
  logic [COUNT_W-1:0] den_r,       den_nxt;
  logic [COUNT_W-1:0] rem_r,       rem_nxt;
  logic [QUO_W-1:0]   quo_r,       quo_nxt;
  logic [STEP_W-1:0]  step_r,      step_nxt;
  out_item_t          res_r,       res_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r,  out_data_nxt;

  // bin store
  bin_word_t          mem [DEPTH];
  bin_word_t          rd_q;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  bin_word_t          wr_data;

  logic               in_acc;
  logic               chan_ok;
  logic [ADDR_W-1:0]  in_addr;
  logic [PROD_W-1:0]  num;
  logic [COUNT_W:0]   trial;
  logic               trial_ge;
  logic               round_up;
  logic [QUO_W:0]     mean_sum;
  logic [MEAN_W-1:0]  mean_new;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign chan_ok   = (32'(in_data.channel) < CHANNELS);
  assign in_addr   = (ADDR_W'(in_data.channel) << BIN_BITS)
                   | ADDR_W'(in_data.raw_value[RAW_W-1 -: BIN_BITS]);
  assign rd_en     = in_acc && chan_ok;
  assign rd_addr   = in_addr;

  assign num       = prod_r + PROD_W'(v_r);
  assign trial     = {rem_r, quo_r[QUO_W-1]};
  assign trial_ge  = (trial >= {1'b0, den_r});
  assign round_up  = ({rem_r, 1'b0} >= {1'b0, den_r});
  assign mean_sum  = {1'b0, quo_r} + (QUO_W+1)'(round_up);
  assign mean_new  = mean_sum[QUO_W] ? '1 : mean_sum[MEAN_W-1:0];

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // One item at a time: the write-back always lands before the next read is issued.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    addr_nxt      = addr_r;
    op_nxt        = op_r;
    v_nxt         = v_r;
    ld_mean_nxt   = ld_mean_r;
    ld_count_nxt  = ld_count_r;
    prod_nxt      = prod_r;
    den_nxt       = den_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    step_nxt      = step_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    wr_addr       = addr_r;
    wr_data       = '0;

    case (state_r)
      S_CLEAR: begin
        wr_en        = 1'b1;
        wr_addr      = clr_addr_r;
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          addr_nxt     = in_addr;
          op_nxt       = in_data.opcode;
          v_nxt        = SRGB_LUT[in_data.ref_value];
          ld_mean_nxt  = in_data.load_mean;
          ld_count_nxt = in_data.load_count;
          if (chan_ok) begin
            state_nxt = S_RD;
          end else begin
            res_nxt   = '0;
            state_nxt = S_OUT;
          end
        end
      end
      S_RD: begin
        res_nxt   = '{mean_out: rd_q.mean, count_out: rd_q.count};
        state_nxt = S_OUT;
        case (op_r)
          OP_ACCUM: begin
            // saturated bin: report unchanged
            if (rd_q.count != COUNT_MAX) begin
              prod_nxt  = PROD_W'(rd_q.mean) * PROD_W'(rd_q.count);
              den_nxt   = rd_q.count + COUNT_W'(1);
              state_nxt = S_ADD;
            end
          end
          OP_LOAD: begin
            wr_en   = 1'b1;
            wr_data = '{count: ld_count_r, mean: ld_mean_r};
            res_nxt = '{mean_out: ld_mean_r, count_out: ld_count_r};
          end
          default: begin
          end
        endcase
      end
      S_ADD: begin
        // quotient fits MEAN_W bits, so the top part already sits below den
        rem_nxt   = num[PROD_W-1 -: COUNT_W];
        quo_nxt   = num[QUO_W-1:0];
        step_nxt  = '1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        rem_nxt  = trial_ge ? COUNT_W'(trial - {1'b0, den_r}) : trial[COUNT_W-1:0];
        quo_nxt  = {quo_r[QUO_W-2:0], trial_ge};
        step_nxt = step_r - STEP_W'(1);
        if (step_r == '0) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        wr_en     = 1'b1;
        wr_data   = '{count: den_r, mean: mean_new};
        res_nxt   = '{mean_out: mean_new, count_out: den_r};
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    addr_r     <= addr_nxt;
    op_r       <= op_nxt;
    v_r        <= v_nxt;
    ld_mean_r  <= ld_mean_nxt;
    ld_count_r <= ld_count_nxt;
    prod_r     <= prod_nxt;
    den_r      <= den_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    step_r     <= step_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  `RSCA_CHECK_NOW(a_div_rem_below_den, state_r == S_FIN, rem_r < den_r, "remainder not below divisor")
  `RSCA_CHECK_NOW(a_mean_no_wrap, state_r == S_FIN, !(quo_r == '1 && round_up), "mean over full scale")
  `RSCA_CHECK_NEXT(a_result_held, state_r == S_OUT && out_valid_r && !out_ready, state_r == S_OUT, "item lost")

endmodule

`default_nettype wire
